@@ design/e2l_pkg.sv @@
// Package for the compressed-header to two-octet-address deframer.
// Beat types, parse phases, register indexes and the address mapping.
// No dependencies.
package e2l_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 4096;

   localparam int BYTE_W   = 8;
   localparam int PKT_W    = 13;
   localparam int LEN_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int RES_MAX  = 4;
   localparam int RES_CNT_W = 3;

   localparam logic [PKT_W-1:0] OFFSET_MAX   = 13'd8191;
   localparam logic [3:0]       TEI_HIGH_CODE = 4'd12;
   localparam logic [5:0]       TEI_SHIFT     = 6'd48;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_VERSION  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_DATA_TAG = 2'd2;

   typedef enum logic [1:0] {
      PH_HDR_HI  = 2'd0,
      PH_HDR_LO  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic [PKT_W-1:0]  packet_bytes;
      logic              packet_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_start;
      logic              frame_end;
   } rsp_type;

   typedef struct packed {
      logic              prefix_enable;
      logic [BYTE_W-1:0] prefix_version;
      logic [BYTE_W-1:0] prefix_data_tag;
   } cfg_type;

   // results of one accepted byte, entry 0 leaves first
   typedef struct packed {
      logic [RES_CNT_W-1:0]       count;
      rsp_type [RES_MAX-1:0]      entry;
   } res_type;

   // first address octet: SAPI << 2 | C/R << 1
   function automatic logic [BYTE_W-1:0] addr_high(input logic [2:0] code);
      logic [BYTE_W-1:0] val;
      unique case (code)
         3'd0:    val = {6'd0,  1'b0, 1'b0};
         3'd1:    val = {6'd0,  1'b1, 1'b0};
         3'd2:    val = {6'd10, 1'b0, 1'b0};
         3'd3:    val = {6'd11, 1'b0, 1'b0};
         3'd4:    val = {6'd12, 1'b0, 1'b0};
         3'd5:    val = {6'd62, 1'b0, 1'b0};
         3'd6:    val = {6'd62, 1'b1, 1'b0};
         default: val = {6'd63, 1'b1, 1'b0};
      endcase
      return val;
   endfunction

   // second address octet: TEI << 1 | EA
   function automatic logic [BYTE_W-1:0] addr_low(input logic [3:0] tcode);
      logic [5:0] tei;
      tei = (tcode >= TEI_HIGH_CODE) ? ({2'b00, tcode} + TEI_SHIFT) : {2'b00, tcode};
      return {1'b0, tei, 1'b1};
   endfunction

endpackage

@@ design/e2l_parser.sv @@
// Header parser and frame state for the deframer.
// Turns one accepted packet byte into up to four output beats.
// Depends on e2l_pkg.
module e2l_parser #(
   parameter int MAX_PACKET_BYTES = e2l_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  e2l_pkg::req_type  req,
   input  e2l_pkg::cfg_type  cfg,
   output e2l_pkg::res_type  res
);
   import e2l_pkg::*;

   localparam int CMP_W = 17;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_PACKET_BYTES);

   phase_type         phase_ff, phase_in;
   logic [PKT_W-1:0]  offset_ff, offset_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [LEN_W-1:0]  left_ff, left_in;

   logic [PKT_W-1:0]  pb;
   logic [PKT_W-1:0]  frame_base;
   logic [PKT_W-1:0]  rem_hi;
   logic [PKT_W-1:0]  rem_lo;
   logic [15:0]       hdr;
   logic [LEN_W-1:0]  len;
   logic [BYTE_W-1:0] a_hi;
   logic [BYTE_W-1:0] a_lo;
   logic              only_hdr;
   logic              fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR_HI;
         offset_ff <= '0;
         left_ff   <= '0;
         held_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         left_ff   <= left_in;
         held_ff   <= held_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      left_in   = left_ff;
      held_in   = held_ff;
      res       = '0;

      // oversize packet counts are clamped
      pb = ({4'd0, req.packet_bytes} > MAX_EXT) ? PKT_W'(MAX_PACKET_BYTES)
                                                : req.packet_bytes;
      frame_base = (offset_ff != '0) ? offset_ff - 1'b1 : '0;
      rem_hi = (pb > offset_ff) ? pb - offset_ff : '0;
      rem_lo = (pb > frame_base) ? pb - frame_base : '0;

      hdr      = {held_ff, req.in_byte};
      len      = hdr[LEN_W-1:0];
      a_hi     = addr_high(hdr[15:13]);
      a_lo     = addr_low(hdr[12:9]);
      only_hdr = (len == LEN_W'(2));
      fin      = (left_ff <= LEN_W'(1)) || req.packet_end;

      unique case (phase_ff)
         PH_HDR_HI: begin
            if (rem_hi <= PKT_W'(2)) begin
               phase_in = PH_DISCARD;
            end else begin
               held_in  = req.in_byte;
               phase_in = PH_HDR_LO;
            end
         end
         PH_HDR_LO: begin
            if (len < LEN_W'(2) || {4'd0, len} > rem_lo) begin
               phase_in = PH_DISCARD;
            end else begin
               if (cfg.prefix_enable) begin
                  res.count    = RES_CNT_W'(4);
                  res.entry[0] = '{cfg.prefix_version, 1'b1, 1'b0};
                  res.entry[1] = '{cfg.prefix_data_tag, 1'b0, 1'b0};
                  res.entry[2] = '{a_hi, 1'b0, 1'b0};
                  res.entry[3] = '{a_lo, 1'b0, only_hdr};
               end else begin
                  res.count    = RES_CNT_W'(2);
                  res.entry[0] = '{a_hi, 1'b1, 1'b0};
                  res.entry[1] = '{a_lo, 1'b0, only_hdr};
               end
               if (only_hdr) begin
                  phase_in = PH_HDR_HI;
               end else begin
                  left_in  = len - LEN_W'(2);
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            res.count    = RES_CNT_W'(1);
            res.entry[0] = '{req.in_byte, 1'b0, fin};
            if (fin) begin
               left_in  = '0;
               phase_in = PH_HDR_HI;
            end else begin
               left_in = left_ff - 1'b1;
            end
         end
         PH_DISCARD: begin
            phase_in = PH_DISCARD;
         end
      endcase

      if (req.packet_end) begin
         offset_in = '0;
         phase_in  = PH_HDR_HI;
         left_in   = '0;
      end else if (offset_ff != OFFSET_MAX) begin
         offset_in = offset_ff + 1'b1;
      end
   end

endmodule

@@ design/ehdlc_to_lapd_deframer_unit.sv @@
// Top level of the compressed-header to two-octet-address deframer.
// Holds the control registers and the output beat queue.
// Depends on e2l_pkg and e2l_parser.
//
// Usage
//   req_*  : packet bytes in, one beat per byte, packet_end on the last.
//   rsp_*  : output frame bytes, frame_start / frame_end mark the frames.
//   csr_*  : write-only registers; index 0 prefix enable, 1 version byte,
//            2 data tag byte. Write only while the block is idle.
// Latency: results of a byte are shown the cycle after it is accepted.
// Throughput: a byte is taken once the queue holds no beat that would still
//   be waiting after this cycle, so the cost of a byte is set by how many
//   beats it makes (one beat a cycle on rsp while rsp is not stalled):
//     header high byte      no beats
//     header low byte       2 beats, 4 with the prefix enabled
//     payload byte          1 beat
//   Sustained payload runs at one byte a cycle while rsp is not stalled.
// Reset empties the queue, clears the registers and restarts parsing at a
// header. A stall on rsp holds the head beat and, while more than nothing
// would remain queued, stalls req as well.
module ehdlc_to_lapd_deframer_unit #(
   parameter int MAX_PACKET_BYTES = e2l_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  e2l_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output e2l_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [e2l_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [e2l_pkg::BYTE_W-1:0]        csr_wdata
);
   import e2l_pkg::*;

   cfg_type               cfg_ff;
   res_type               res;
   rsp_type [RES_MAX-1:0] queue_ff, queue_in;
   logic [RES_CNT_W-1:0]  count_ff, count_in;
   logic                  accept;
   logic                  pop;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PREFIX_ENABLE:   cfg_ff.prefix_enable   <= csr_wdata[0];
            CSR_PREFIX_VERSION:  cfg_ff.prefix_version  <= csr_wdata;
            CSR_PREFIX_DATA_TAG: cfg_ff.prefix_data_tag <= csr_wdata;
            default: ;
         endcase
      end
   end

   e2l_parser #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .res   (res)
   );

   // queue head is the output register; a byte enters once the queue drains
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((count_ff == '0) || (count_ff == RES_CNT_W'(1) && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      queue_in = queue_ff;
      count_in = count_ff;
      if (accept) begin
         // queue is empty after this cycle's pop: load the new beats
         queue_in = res.entry;
         count_in = res.count;
      end else if (pop) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            queue_in[i] = queue_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[0];

endmodule

@@ design/e2l_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends on e2l_pkg and ehdlc_to_lapd_deframer_unit.
module e2l_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input e2l_pkg::rsp_type      rsp_payload
);
   import e2l_pkg::*;

   // nothing is left to show after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("beat shown straight after reset");

   // a held output beat keeps the input side stalled
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output is stalled");

   // every frame carries at least the two address octets
   a_no_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_start |-> !rsp_payload.frame_end)
      else $error("one-byte frame");

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled beat changed");

endmodule

bind ehdlc_to_lapd_deframer_unit e2l_checker u_e2l_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

@@ dv/ehdlc_to_lapd_deframer_unit_tb.sv @@
// Self-checking testbench for ehdlc_to_lapd_deframer_unit: packets of
// compressed-header frames in, predicted two-octet-address frame beats out.
// Depends on e2l_pkg and the deframer RTL; needs no other file.
module ehdlc_to_lapd_deframer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import e2l_pkg::*;

   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off in the last phase
   localparam int SETTLE_CYCLES = 8;     // quiet time before a register write or the end
   localparam int PHASE_BYTES   = 60;    // random bytes per random phase
   localparam int MAX_PRINTED   = 20;

   // ------------------------------------------------------------------
   // DUT signals, every input known from time zero
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PREFIX_ENABLE;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   ehdlc_to_lapd_deframer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   req_type    bytes_to_send[$];      // packet bytes waiting for the driver
   rsp_type    out_beats_due[$];      // predicted output beats, oldest first

   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_req_cnt = 0;      // bumped by the sequencer to ask for a hold-off

   int         err_count = 0;
   int         bytes_queued = 0;
   int         bytes_taken = 0;
   int         beats_seen = 0;
   int         frames_seen = 0;
   int         req_held_cycles = 0;

   // predictor's copy of the registers and parser state
   cfg_type    cfg_copy = '0;
   phase_type  parse_at = PH_HDR_HI;
   int unsigned pkt_pos = 0;          // bytes of the packet taken so far, saturating
   logic [7:0] hdr_first = '0;
   int unsigned payload_due = 0;

   // compressed SAPI code -> SAPI and C/R
   localparam int unsigned SAPI_MAP[8] = '{0, 0, 10, 11, 12, 62, 62, 63};
   localparam bit          CR_MAP[8]   = '{0, 1, 0, 0, 0, 0, 1, 1};

   // ------------------------------------------------------------------
   // Predictor: one accepted packet byte -> zero to four output beats
   // ------------------------------------------------------------------
   function automatic void push_beat(input logic [7:0] b, input logic s, input logic e);
      rsp_type r;
      r.out_byte    = b;
      r.frame_start = s;
      r.frame_end   = e;
      out_beats_due.push_back(r);
   endfunction

   function automatic void deframe_byte(input req_type r);
      int unsigned pb;
      int unsigned flen;
      int unsigned start_pos;
      int unsigned room;
      logic [15:0] hdr;
      logic [2:0]  scode;
      logic [3:0]  tcode;
      logic [5:0]  tei;
      logic        fin;

      // oversize packet counts are clamped to the largest packet
      pb = (r.packet_bytes > MAX_PACKET_BYTES_DEF) ? MAX_PACKET_BYTES_DEF : r.packet_bytes;

      case (parse_at)
         PH_HDR_HI: begin
            // two bytes or fewer left cannot hold a frame: drop the rest
            if (pb <= pkt_pos + 2) begin
               parse_at = PH_DISCARD;
            end else begin
               hdr_first = r.in_byte;
               parse_at  = PH_HDR_LO;
            end
         end
         PH_HDR_LO: begin
            hdr       = {hdr_first, r.in_byte};
            scode     = hdr[15:13];
            tcode     = hdr[12:9];
            flen      = hdr[8:0];
            start_pos = (pkt_pos > 0) ? pkt_pos - 1 : 0;
            room      = (pb > start_pos) ? pb - start_pos : 0;
            // too long for the packet, or a length that cannot cover the header
            if (flen < 2 || flen > room) begin
               parse_at = PH_DISCARD;
            end else begin
               tei = (tcode >= 12) ? 6'(tcode) + 6'd48 : 6'(tcode);
               if (cfg_copy.prefix_enable) begin
                  push_beat(cfg_copy.prefix_version, 1'b1, 1'b0);
                  push_beat(cfg_copy.prefix_data_tag, 1'b0, 1'b0);
               end
               push_beat({6'(SAPI_MAP[scode]), CR_MAP[scode], 1'b0},
                         !cfg_copy.prefix_enable, 1'b0);
               // header-only frame ends on the second address octet
               push_beat({1'b0, tei, 1'b1}, 1'b0, flen == 2);
               if (flen == 2) begin
                  parse_at = PH_HDR_HI;
               end else begin
                  payload_due = flen - 2;
                  parse_at    = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            // packet_end mid-payload cuts the frame short
            fin = (payload_due <= 1) || r.packet_end;
            push_beat(r.in_byte, 1'b0, fin);
            if (payload_due > 0) payload_due--;
            if (fin) begin
               payload_due = 0;
               parse_at    = PH_HDR_HI;
            end
         end
         default: ;
      endcase

      if (r.packet_end) begin
         pkt_pos     = 0;
         parse_at    = PH_HDR_HI;
         payload_due = 0;
      end else if (pkt_pos < OFFSET_MAX) begin
         pkt_pos++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers packet bytes, predicts each one as it is accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_payload);
            bytes_taken++;
         end
         if (req_valid && req_stall) req_held_cycles++;
         // a stalled beat stays put; otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= bytes_to_send.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure: random stalls, plus a long counted hold-off
   // ------------------------------------------------------------------
   int hold_left = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_req_cnt) begin
         hold_seen <= hold_req_cnt;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every accepted output beat against the oldest prediction
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < MAX_PRINTED)
         $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $realtime, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (rsp_payload.frame_end) frames_seen++;
         if (out_beats_due.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_payload), 0);
         end else begin
            want = out_beats_due.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_payload.out_byte),
                               int'(want.out_byte));
            if (rsp_payload.frame_start !== want.frame_start)
               report_mismatch("frame_start", int'(rsp_payload.frame_start),
                               int'(want.frame_start));
            if (rsp_payload.frame_end !== want.frame_end)
               report_mismatch("frame_end", int'(rsp_payload.frame_end),
                               int'(want.frame_end));
         end
      end
   end

   // ------------------------------------------------------------------
   // Packet building
   // ------------------------------------------------------------------
   function automatic logic [15:0] make_header(input logic [2:0] scode,
                                               input logic [3:0] tcode,
                                               input logic [8:0] flen);
      return {scode, tcode, flen};
   endfunction

   // header plus npay random payload bytes
   task automatic add_frame(ref logic [7:0] pkt[$], input logic [2:0] scode,
                            input logic [3:0] tcode, input logic [8:0] flen,
                            input int npay);
      logic [15:0] hdr;
      hdr = make_header(scode, tcode, flen);
      pkt.push_back(hdr[15:8]);
      pkt.push_back(hdr[7:0]);
      repeat (npay) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_good_frame(ref logic [7:0] pkt[$]);
      int flen;
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 8);
      add_frame(pkt, 3'($urandom), 4'($urandom), 9'(flen), flen - 2);
   endtask

   // packet_end goes on the last byte; claimed is the packet_bytes value
   task automatic send_packet(input logic [7:0] pkt[$], input int claimed);
      req_type r;
      foreach (pkt[i]) begin
         r.in_byte      = pkt[i];
         r.packet_bytes = PKT_W'(claimed);
         r.packet_end   = (i == pkt.size() - 1);
         bytes_to_send.push_back(r);
         bytes_queued++;
      end
   endtask

   task automatic queue_random_packet();
      logic [7:0] pkt[$];
      int sel;
      int flen;
      int npay;
      int claimed;
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
         // well-formed, now and then with a one- or two-byte tail
         repeat ($urandom_range(1, 4)) add_good_frame(pkt);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom_range(0, 255)));
         claimed = pkt.size();
      end else if (sel == 6) begin
         // last frame claims more than the packet still holds
         repeat ($urandom_range(0, 2)) add_good_frame(pkt);
         add_frame(pkt, 3'($urandom), 4'($urandom), 9'($urandom_range(4, 511)),
                   $urandom_range(0, 1));
         claimed = pkt.size();
      end else if (sel == 7) begin
         // header with length zero or one, then some leftovers
         repeat ($urandom_range(0, 2)) add_good_frame(pkt);
         add_frame(pkt, 3'($urandom), 4'($urandom), 9'($urandom_range(0, 1)),
                   $urandom_range(1, 3));
         claimed = pkt.size();
      end else if (sel == 8) begin
         // packet ends inside a payload
         repeat ($urandom_range(0, 1)) add_good_frame(pkt);
         flen = $urandom_range(4, 12);
         npay = $urandom_range(1, flen - 3);
         add_frame(pkt, 3'($urandom), 4'($urandom), 9'(flen), npay);
         claimed = pkt.size() + (flen - 2 - npay);
      end else begin
         // noise with an arbitrary byte count, over or under the bytes sent
         repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
         claimed = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8191)
                                               : $urandom_range(1, pkt.size());
      end
      send_packet(pkt, claimed);
   endtask

   task automatic queue_directed();
      logic [7:0] pkt[$];
      // header-only frame (SAPI 63, top TEI) then a one-byte payload frame
      add_frame(pkt, 3'd7, 4'd15, 9'd2, 0);
      add_frame(pkt, 3'd0, 4'd12, 9'd3, 0);
      pkt.push_back(8'hFF);
      send_packet(pkt, 5);
      // frame longer than the packet
      pkt.delete();
      add_frame(pkt, 3'd3, 4'd11, 9'd511, 2);
      send_packet(pkt, 4);
      // length below the header size
      pkt.delete();
      add_frame(pkt, 3'd2, 4'd0, 9'd0, 1);
      send_packet(pkt, 3);
      // only two bytes in the packet
      pkt = '{8'hFF, 8'h00};
      send_packet(pkt, 2);
      // packet_end in the middle of a payload
      pkt.delete();
      add_frame(pkt, 3'd5, 4'd13, 9'd6, 2);
      send_packet(pkt, 6);
      // packet_end on a header's first byte
      pkt = '{8'hFF};
      send_packet(pkt, 5);
      // bytes beyond the stated packet size
      pkt.delete();
      add_frame(pkt, 3'd1, 4'd3, 9'd3, 1);
      pkt.push_back(8'h5A);
      pkt.push_back(8'hA5);
      send_packet(pkt, 3);
      // packet size above the maximum, all ones
      pkt.delete();
      add_frame(pkt, 3'd6, 4'd14, 9'd3, 1);
      send_packet(pkt, 8191);
   endtask

   // ------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------
   task automatic write_regs(input logic en, input logic [7:0] ver, input logic [7:0] tag);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PREFIX_ENABLE;
      csr_wdata <= {7'd0, en};
      @(posedge clock);
      csr_index <= CSR_PREFIX_VERSION;
      csr_wdata <= ver;
      @(posedge clock);
      csr_index <= CSR_PREFIX_DATA_TAG;
      csr_wdata <= tag;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_copy.prefix_enable   = en;
      cfg_copy.prefix_version  = ver;
      cfg_copy.prefix_data_tag = tag;
   endtask

   // all bytes taken, all beats back, then a settle wait since a
   // header byte makes no beat but may still be in flight
   task automatic wait_drained();
      do @(posedge clock);
      while (bytes_to_send.size() != 0 || req_valid || out_beats_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      int target;
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) queue_random_packet();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed cases, prefix on with extreme prefix bytes, no idling
      write_regs(1'b1, 8'h00, 8'hFF);
      queue_directed();
      wait_drained();

      // sender rarely idles, receiver mostly stalls
      write_regs(1'b0, 8'hFF, 8'h00);
      @(posedge clock);
      send_idle_pct <= 9;
      recv_idle_pct <= 69;
      random_phase();
      wait_drained();

      // the other way round
      write_regs(1'b1, 8'hFF, 8'hFF);
      @(posedge clock);
      send_idle_pct <= 69;
      recv_idle_pct <= 9;
      random_phase();
      wait_drained();

      // full rate both sides, with one long hold-off so the block backs up
      write_regs(1'b1, 8'($urandom), 8'($urandom));
      @(posedge clock);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_phase();
      hold_req_cnt <= hold_req_cnt + 1;
      wait_drained();

      $display("%0d packet bytes taken, %0d frame beats checked over %0d frames",
               bytes_taken, beats_seen, frames_seen);
      $display("four register settings, input held off for %0d cycles by back-pressure",
               req_held_cycles);
      if (err_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d beats still due", out_beats_due.size());
      $display("simulation failed");
      $finish;
   end

endmodule
